// ===== rtl/itcm_pkg.sv =====
package itcm_pkg;

  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  localparam int VIEW_W     = 21;
  localparam int TILE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int NUM_W  = 33;
  localparam int DEN_W  = 18;
  localparam int N3_W   = 40;
  localparam int D3_W   = 9;
  localparam int OP_A_W = 23;
  localparam int OP_B_W = 10;
  localparam int PROD_W = 33;
  localparam int VAL_W  = 35;
  localparam int MUL_W  = 45;
  localparam int QDEPTH = 8;
  localparam int ODEPTH = 2;

  localparam logic       FUNC_TO_CELL = 1'b0;
  localparam logic [1:0] MODE_RST     = 2'd0;
  localparam logic [8:0] TW_RST       = 9'd32;
  localparam logic [8:0] TH_RST       = 9'd16;
  localparam logic [8:0] TILE_MIN     = 9'd2;
  localparam logic [8:0] TILE_MAX     = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_TILE_W = 3'd1,
    CFG_TILE_H = 3'd2,
    CFG_VIEW_X = 3'd3,
    CFG_VIEW_Y = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STAG = 2'd0,
    MODE_DIAM = 2'd1,
    MODE_ORTH = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    K_CELL_STAG = 3'd0,
    K_CELL_DIAM = 3'd1,
    K_CELL_ORTH = 3'd2,
    K_SCR_STAG  = 3'd3,
    K_SCR_DIAM  = 3'd4,
    K_SCR_ORTH  = 3'd5
  } kind_t;

  typedef struct packed {
    logic                   func;
    logic signed [IN_W-1:0] in_x;
    logic signed [IN_W-1:0] in_y;
  } itcm_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         clipped;
  } itcm_out_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic [TILE_W-1:0]        tw;
    logic [TILE_W-1:0]        th;
    logic [7:0]               half_w;
    logic [7:0]               half_h;
    logic [16:0]              hsq;
    logic [16:0]              area;
    logic [15:0]              diam_d;
    logic [15:0]              diam_k;
    logic signed [VIEW_W-1:0] vx;
    logic signed [VIEW_W-1:0] vy;
  } geom_t;

  typedef struct packed {
    logic             stag;
    logic [NUM_W-1:0] n1;
    logic [DEN_W-1:0] d1;
    logic             s1;
    logic [NUM_W-1:0] n2;
    logic [DEN_W-1:0] d2;
    logic             s2;
  } itcm_job_t;

  function automatic logic [TILE_W-1:0] tile_clamp(input logic [TILE_W-1:0] raw);
    logic [TILE_W-1:0] s;
    s = raw;
    if (raw < TILE_MIN) s = TILE_MIN;
    if (raw > TILE_MAX) s = TILE_MAX;
    return s;
  endfunction

  function automatic geom_t geom_calc(input logic [1:0] mode,
                                      input logic [TILE_W-1:0] tw_raw,
                                      input logic [TILE_W-1:0] th_raw,
                                      input logic signed [VIEW_W-1:0] vx,
                                      input logic signed [VIEW_W-1:0] vy);
    geom_t g;
    g.mode   = mode;
    g.tw     = tile_clamp(tw_raw);
    g.th     = tile_clamp(th_raw);
    g.half_w = g.tw[8:1];
    g.half_h = g.th[8:1];
    g.hsq    = 17'(g.th) * 17'(g.th);
    g.area   = 17'(g.tw) * 17'(g.th);
    g.diam_d = 16'({17'(g.half_w) * 17'(g.half_h), 1'b0});
    g.diam_k = 16'(16'(g.half_h) * 16'(g.tw));
    g.vx     = vx;
    g.vy     = vy;
    return g;
  endfunction

endpackage

// ===== rtl/itcm_div.sv =====
module itcm_div #(
  parameter int NW = 33,
  parameter int DW = 18,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_n,
  input  logic [DW-1:0] in_d,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [NW-1:0] out_q,
  output logic [TW-1:0] out_tag
);

  logic          vld_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] d_r   [NW];
  logic [TW-1:0] tag_r [NW];

  // one quotient bit per stage; numerator shifts out as quotient shifts in
  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] nq_p;
    logic [DW-1:0] d_p;
    logic [TW-1:0] tag_p;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p   = in_vld;
      assign rem_p = '0;
      assign nq_p  = in_n;
      assign d_p   = in_d;
      assign tag_p = in_tag;
    end else begin : g_next
      assign v_p   = vld_r[k-1];
      assign rem_p = rem_r[k-1];
      assign nq_p  = nq_r[k-1];
      assign d_p   = d_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    assign t  = {rem_p, nq_p[NW-1]};
    assign ge = t >= {1'b0, d_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(t - {1'b0, d_p}) : t[DW-1:0];
        nq_r[k]  <= {nq_p[NW-2:0], ge};
        d_r[k]   <= d_p;
        tag_r[k] <= tag_p;
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign out_q   = nq_r[NW-1];
  assign out_tag = tag_r[NW-1];

endmodule

// ===== rtl/itcm_fifo.sv =====
module itcm_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  item_t                      wdata,
  input  logic                       pop,
  output item_t                      rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_nxt;
      if (pop) rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

  assign rdata = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign count = cnt_r;

endmodule

// ===== rtl/itcm_front.sv =====
module itcm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  itcm_pkg::itcm_in_t   item,
  input  itcm_pkg::geom_t      geom,
  output logic                 job_vld,
  output itcm_pkg::itcm_job_t  job,
  output logic [1:0]           inflight
);
  import itcm_pkg::*;

  // stage 1: view offset, operand selection
  logic signed [21:0]         x, y;
  logic signed [OP_A_W-1:0]   px;
  logic signed [17:0]         e1;
  logic signed [16:0]         e2;
  kind_t                      kind_c;
  logic signed [OP_A_W-1:0]   a1_c, a2_c;
  logic signed [OP_B_W-1:0]   b1_c, b2_c;
  logic signed [OP_B_W-1:0]   tw_s, th_s, hw_s, hh_s, w2_s;

  logic                       v1_r;
  kind_t                      kind1_r;
  logic                       iy0_1_r;
  logic signed [OP_A_W-1:0]   a1_r, a2_r;
  logic signed [OP_B_W-1:0]   b1_r, b2_r;

  // stage 2: products
  logic signed [PROD_W-1:0]   p1_c, p2_c;
  logic                       v2_r;
  kind_t                      kind2_r;
  logic                       iy0_2_r;
  logic signed [PROD_W-1:0]   p1_r, p2_r;

  // stage 3: numerators
  logic signed [VAL_W-1:0]    val1_c, val2_c;
  logic signed [VAL_W-1:0]    hsq_s, dk_s, hw_v, vx_v, vy_v;
  logic                       v3_r;
  kind_t                      kind3_r;
  logic signed [VAL_W-1:0]    val1_r, val2_r;

  // stage 4: magnitudes, rounding offsets, divisors
  logic                       s1, s2, rnd;
  logic [VAL_W-1:0]           mag1, mag2;

  assign x    = 22'(geom.vx) + 22'(item.in_x);
  assign y    = 22'(geom.vy) + 22'(item.in_y);
  assign px   = OP_A_W'(x) - OP_A_W'($signed({1'b0, geom.half_w}));
  assign e1   = 18'(item.in_x) - 18'(item.in_y) + 18'sd1;
  assign e2   = 17'(item.in_x) + 17'(item.in_y);
  assign tw_s = $signed({1'b0, geom.tw});
  assign th_s = $signed({1'b0, geom.th});
  assign hw_s = $signed({2'b00, geom.half_w});
  assign hh_s = $signed({2'b00, geom.half_h});
  assign w2_s = $signed({1'b0, geom.half_w, 1'b0});

  always_comb begin
    if (item.func == FUNC_TO_CELL) begin
      case (mode_t'(geom.mode))
        MODE_STAG: kind_c = K_CELL_STAG;
        MODE_DIAM: kind_c = K_CELL_DIAM;
        default:   kind_c = K_CELL_ORTH;
      endcase
    end else begin
      case (mode_t'(geom.mode))
        MODE_STAG: kind_c = K_SCR_STAG;
        MODE_DIAM: kind_c = K_SCR_DIAM;
        default:   kind_c = K_SCR_ORTH;
      endcase
    end
  end

  always_comb begin
    case (kind_c)
      K_CELL_STAG: begin
        a1_c = px;             b1_c = th_s;
        a2_c = OP_A_W'(y);     b2_c = tw_s;
      end
      K_CELL_DIAM: begin
        a1_c = OP_A_W'(x);     b1_c = hh_s;
        a2_c = OP_A_W'(y);     b2_c = hw_s;
      end
      K_SCR_STAG: begin
        a1_c = OP_A_W'(item.in_x); b1_c = w2_s;
        a2_c = OP_A_W'(item.in_y); b2_c = hh_s;
      end
      K_SCR_DIAM: begin
        a1_c = OP_A_W'(e1);    b1_c = hw_s;
        a2_c = OP_A_W'(e2);    b2_c = hh_s;
      end
      K_SCR_ORTH: begin
        a1_c = OP_A_W'(item.in_x); b1_c = tw_s;
        a2_c = OP_A_W'(item.in_y); b2_c = th_s;
      end
      default: begin
        a1_c = OP_A_W'(x);     b1_c = OP_B_W'(1);
        a2_c = OP_A_W'(y);     b2_c = OP_B_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    kind1_r <= kind_c;
    iy0_1_r <= item.in_y[0];
    a1_r    <= a1_c;
    b1_r    <= b1_c;
    a2_r    <= a2_c;
    b2_r    <= b2_c;
  end

  assign p1_c = PROD_W'(a1_r) * PROD_W'(b1_r);
  assign p2_c = PROD_W'(a2_r) * PROD_W'(b2_r);

  always_ff @(posedge clk) begin
    kind2_r <= kind1_r;
    iy0_2_r <= iy0_1_r;
    p1_r    <= p1_c;
    p2_r    <= p2_c;
  end

  assign hsq_s = VAL_W'($signed({1'b0, geom.hsq}));
  assign dk_s  = VAL_W'($signed({1'b0, geom.diam_k}));
  assign hw_v  = iy0_2_r ? VAL_W'($signed({1'b0, geom.half_w})) : '0;
  assign vx_v  = VAL_W'(geom.vx);
  assign vy_v  = VAL_W'(geom.vy);

  always_comb begin
    case (kind2_r)
      K_CELL_STAG: begin
        val1_c = VAL_W'(p1_r) + VAL_W'(p2_r) - hsq_s;
        val2_c = VAL_W'(p2_r) - VAL_W'(p1_r) - hsq_s;
      end
      K_CELL_DIAM: begin
        val1_c = VAL_W'(p1_r) + VAL_W'(p2_r) - dk_s;
        val2_c = VAL_W'(p2_r) - VAL_W'(p1_r) + dk_s;
      end
      K_CELL_ORTH: begin
        val1_c = VAL_W'(p1_r);
        val2_c = VAL_W'(p2_r);
      end
      K_SCR_STAG: begin
        val1_c = VAL_W'(p1_r) + hw_v - vx_v;
        val2_c = VAL_W'(p2_r) - vy_v;
      end
      default: begin
        val1_c = VAL_W'(p1_r) - vx_v;
        val2_c = VAL_W'(p2_r) - vy_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind3_r <= kind2_r;
    val1_r  <= val1_c;
    val2_r  <= val2_c;
  end

  assign s1   = val1_r[VAL_W-1];
  assign s2   = val2_r[VAL_W-1];
  assign mag1 = s1 ? VAL_W'(-val1_r) : VAL_W'(val1_r);
  assign mag2 = s2 ? VAL_W'(-val2_r) : VAL_W'(val2_r);
  assign rnd  = (kind3_r == K_CELL_STAG);

  // half away from zero: (2|n| + d) / 2d
  always_comb begin
    job.stag = rnd;
    job.s1   = s1;
    job.s2   = s2;
    job.n1   = rnd ? NUM_W'({mag1, 1'b0} + (VAL_W + 1)'(geom.area)) : NUM_W'(mag1);
    job.n2   = rnd ? NUM_W'({mag2, 1'b0} + (VAL_W + 1)'(geom.area)) : NUM_W'(mag2);
    case (kind3_r)
      K_CELL_STAG: begin
        job.d1 = DEN_W'({geom.area, 1'b0});
        job.d2 = DEN_W'({geom.area, 1'b0});
      end
      K_CELL_DIAM: begin
        job.d1 = DEN_W'(geom.diam_d);
        job.d2 = DEN_W'(geom.diam_d);
      end
      K_CELL_ORTH: begin
        job.d1 = DEN_W'(geom.tw);
        job.d2 = DEN_W'(geom.th);
      end
      default: begin
        job.d1 = DEN_W'(1);
        job.d2 = DEN_W'(1);
      end
    endcase
  end

  assign job_vld  = v3_r;
  assign inflight = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);

endmodule

// ===== rtl/itcm_back.sv =====
module itcm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  itcm_pkg::itcm_job_t  q_head,
  output logic                 q_pop,
  input  logic                 out_full,
  input  itcm_pkg::geom_t      geom,
  output logic                 res_vld,
  output itcm_pkg::itcm_out_t  res
);
  import itcm_pkg::*;

  localparam int T3_W = VAL_W + 1;
  localparam int R1_W = N3_W + 1;
  localparam logic signed [R1_W-1:0] R1_MAX = R1_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [R1_W-1:0] R1_MIN = R1_W'(-(64'sd1 <<< (COORD_BITS - 1)));
  localparam logic signed [VAL_W-1:0] R2_MAX = VAL_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [VAL_W-1:0] R2_MIN = VAL_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  logic              en;
  logic              d1_vld, d2_vld, d3_vld;
  logic [NUM_W-1:0]  q1, q2;
  logic [1:0]        tag1;
  logic [0:0]        tag2;
  logic [N3_W-1:0]   q3;
  logic [T3_W-1:0]   tag3;

  logic signed [NUM_W:0]   qs1, qs2;
  logic signed [VAL_W-1:0] t1_c, t2_c;
  logic                    m1_v_r, m1_stag_r;
  logic signed [VAL_W-1:0] t1_r, t2_r;

  logic signed [MUL_W-1:0] prod_c;
  logic                    m2_v_r, m2_stag_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [VAL_W-1:0] t2b_r;

  logic                    neg;
  logic [MUL_W-1:0]        mag;
  logic [N3_W-1:0]         n3;
  logic [D3_W-1:0]         d3;

  logic signed [R1_W-1:0]  r1;
  logic signed [VAL_W-1:0] r2;
  logic                    hi1, lo1, hi2, lo2;

  // whole back end advances together; holds only when the last result cannot leave
  assign en    = !(d3_vld && out_full);
  assign q_pop = en && !q_empty;

  itcm_div #(.NW(NUM_W), .DW(DEN_W), .TW(2)) u_div1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (!q_empty),
    .in_n   (q_head.n1),
    .in_d   (q_head.d1),
    .in_tag ({q_head.stag, q_head.s1}),
    .out_vld(d1_vld),
    .out_q  (q1),
    .out_tag(tag1)
  );

  itcm_div #(.NW(NUM_W), .DW(DEN_W), .TW(1)) u_div2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (!q_empty),
    .in_n   (q_head.n2),
    .in_d   (q_head.d2),
    .in_tag (q_head.s2),
    .out_vld(d2_vld),
    .out_q  (q2),
    .out_tag(tag2)
  );

  assign qs1  = tag1[0] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
  assign qs2  = tag2[0] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
  assign t1_c = tag1[1] ? VAL_W'(qs1) - VAL_W'(qs2) : VAL_W'(qs1);
  assign t2_c = tag1[1] ? VAL_W'(qs1) + VAL_W'(qs2) : VAL_W'(qs2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= d1_vld && d2_vld;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_stag_r <= tag1[1];
      t1_r      <= t1_c;
      t2_r      <= t2_c;
    end
  end

  assign prod_c = m1_stag_r ? MUL_W'(t1_r) * MUL_W'($signed({1'b0, geom.th}))
                            : MUL_W'(t1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m2_stag_r <= m1_stag_r;
      prod_r    <= prod_c;
      t2b_r     <= t2_r;
    end
  end

  // floor for negative numerators: -(|n| + W - 1) / W
  assign neg = prod_r[MUL_W-1];
  assign mag = neg ? MUL_W'(-prod_r) : MUL_W'(prod_r);
  assign n3  = N3_W'(mag) + ((m2_stag_r && neg) ? N3_W'(geom.tw) - N3_W'(1) : '0);
  assign d3  = m2_stag_r ? geom.tw : D3_W'(1);

  itcm_div #(.NW(N3_W), .DW(D3_W), .TW(T3_W)) u_div3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (m2_v_r),
    .in_n   (n3),
    .in_d   (d3),
    .in_tag ({neg, t2b_r}),
    .out_vld(d3_vld),
    .out_q  (q3),
    .out_tag(tag3)
  );

  assign r1  = tag3[T3_W-1] ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
  assign r2  = $signed(tag3[VAL_W-1:0]);
  assign hi1 = r1 > R1_MAX;
  assign lo1 = r1 < R1_MIN;
  assign hi2 = r2 > R2_MAX;
  assign lo2 = r2 < R2_MIN;

  always_comb begin
    res.out_x   = hi1 ? COORD_BITS'(R1_MAX) : lo1 ? COORD_BITS'(R1_MIN) : COORD_BITS'(r1);
    res.out_y   = hi2 ? COORD_BITS'(R2_MAX) : lo2 ? COORD_BITS'(R2_MIN) : COORD_BITS'(r2);
    res.clipped = hi1 || lo1 || hi2 || lo2;
  end

  assign res_vld = d3_vld && !out_full;

endmodule

// ===== rtl/isometric_tile_coordinate_mapper_top.sv =====
// Isometric tile coordinate mapper.
// Input queue side: drive in_item and raise push; the request is taken on a
// clock edge where push is high and full is low. func 0 maps a screen pixel
// to a cell, func 1 maps a cell to its screen pixel.
// Result queue side: while empty is low, out_item holds the oldest result;
// it is removed on an edge where pop is high. Results keep request order.
// Config port: cfg_index/cfg_data written on cfg_valid (cfg_ready is always
// high); index 0 projection, 1 tile width, 2 tile height, 3 view x, 4 view y.
// Write only while no request is in flight.
// Throughput: one request per cycle, sustained with pop held high.
// Push to empty falling passes front stages, middle queue and two bit-serial
// divider pipelines in series (33 stages, then 40). With pop low the back end
// freezes when a result waits on a full result queue; full rises once queued
// plus in-flight jobs fill the 8-entry middle queue. Nothing is dropped.
// Reset (rst_n low, synchronous) empties all queues and loads staggered mode,
// 32x16 tiles and a zero view offset.
module isometric_tile_coordinate_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  itcm_pkg::itcm_in_t                  in_item,
  output logic                                empty,
  input  logic                                pop,
  output itcm_pkg::itcm_out_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [itcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import itcm_pkg::*;

  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  logic [1:0]               mode_r;
  logic [TILE_W-1:0]        tw_r, th_r;
  logic signed [VIEW_W-1:0] vx_r, vy_r;
  geom_t                    geom;

  logic        in_acc;
  logic        job_vld;
  itcm_job_t   job;
  logic [1:0]  inflight;

  itcm_job_t   q_head;
  logic        q_empty, q_full, q_pop;
  logic [QCW-1:0] q_count;

  logic        res_vld;
  itcm_out_t   res;
  logic        of_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      tw_r   <= TW_RST;
      th_r   <= TH_RST;
      vx_r   <= '0;
      vy_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r <= cfg_data[1:0];
        CFG_TILE_W: tw_r   <= cfg_data[TILE_W-1:0];
        CFG_TILE_H: th_r   <= cfg_data[TILE_W-1:0];
        CFG_VIEW_X: vx_r   <= $signed(cfg_data[VIEW_W-1:0]);
        CFG_VIEW_Y: vy_r   <= $signed(cfg_data[VIEW_W-1:0]);
        default: ;
      endcase
    end
  end

  assign geom = geom_calc(mode_r, tw_r, th_r, vx_r, vy_r);

  // leave room in the middle queue for everything still in the front stages
  assign full   = (QCW'(q_count) + QCW'(inflight)) >= QCW'(QDEPTH);
  assign in_acc = push && !full;

  itcm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .item    (in_item),
    .geom    (geom),
    .job_vld (job_vld),
    .job     (job),
    .inflight(inflight)
  );

  itcm_fifo #(.item_t(itcm_job_t), .DEPTH(QDEPTH)) u_jobq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_vld),
    .wdata(job),
    .pop  (q_pop),
    .rdata(q_head),
    .empty(q_empty),
    .full (q_full),
    .count(q_count)
  );

  itcm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_full(of_full),
    .geom    (geom),
    .res_vld (res_vld),
    .res     (res)
  );

  itcm_fifo #(.item_t(itcm_out_t), .DEPTH(ODEPTH)) u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_vld),
    .wdata(res),
    .pop  (pop && !empty),
    .rdata(out_item),
    .empty(empty),
    .full (of_full),
    .count()
  );

  a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_vld && q_full))
    else $error("job queue written while full");

  a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_vld && of_full))
    else $error("result queue written while full");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.clipped) |->
      (out_item.out_x == C_MAX || out_item.out_x == C_MIN ||
       out_item.out_y == C_MAX || out_item.out_y == C_MIN))
    else $error("clipped result not at a saturation rail");

endmodule
